// ----- rtl/ale_pkg.sv -----
`default_nettype none

package ale_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int ST_W     = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_SORT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOC      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	// next read address select
	localparam logic [2:0] RS_HOLD = 3'd0;
	localparam logic [2:0] RS_INC  = 3'd1;
	localparam logic [2:0] RS_DEC  = 3'd2;
	localparam logic [2:0] RS_LAST = 3'd3;
	localparam logic [2:0] RS_POS  = 3'd4;
	localparam logic [2:0] RS_ZERO = 3'd5;

	// write select
	localparam logic [1:0] WS_UP    = 2'd0;
	localparam logic [1:0] WS_DN    = 2'd1;
	localparam logic [1:0] WS_PLACE = 2'd2;

	// result index select
	localparam logic [1:0] IS_ZERO = 2'd0;
	localparam logic [1:0] IS_INS  = 2'd1;
	localparam logic [1:0] IS_POS  = 2'd2;
	localparam logic [1:0] IS_CUR  = 2'd3;

	typedef struct packed {
		logic            ld_in;
		logic [2:0]      rsel;
		logic            we;
		logic [1:0]      wsel;
		logic            ins_ld;
		logic            ins_inc;
		logic            cnt_inc;
		logic            cnt_dec;
		logic            res_ld;
		logic [ST_W-1:0] res_status;
		logic            res_vrd;
		logic [1:0]      res_isel;
		logic            out_ld;
		logic            out_dump;
	} ale_ctl_t;

	typedef struct packed {
		logic [ST_W-1:0] err;
		logic            cnt_zero;
		logic            cont;
		logic            cur_zero;
		logic            at_end;
		logic            first;
		logic            match;
		logic            out_free;
	} ale_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ale_ram.sv -----
`default_nettype none

module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ale_dp.sv -----
`default_nettype none

module ale_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [ale_pkg::CMD_W-1:0]           command,
	input  wire logic signed [ale_pkg::DATA_W-1:0]   value,
	input  wire logic [ale_pkg::CNT_W-1:0]           position,
	input  wire ale_pkg::ale_ctl_t                   ctl,
	output ale_pkg::ale_sts_t                        sts,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic [ale_pkg::ST_W-1:0]                 status,
	output logic signed [ale_pkg::DATA_W-1:0]        value_out,
	output logic [ale_pkg::IDX_W-1:0]                index_out,
	output logic [ale_pkg::CNT_W-1:0]                entry_count,
	output logic                                     last
);

	logic [ale_pkg::CMD_W-1:0]  cmd_q;
	logic [ale_pkg::DATA_W-1:0] val_q;
	logic [ale_pkg::CNT_W-1:0]  pos_q;
	logic [ale_pkg::CNT_W-1:0]  cnt_q;
	logic [ale_pkg::IDX_W-1:0]  cur_q;
	logic [ale_pkg::IDX_W-1:0]  ins_q;

	logic [ale_pkg::ST_W-1:0]   res_status_q;
	logic [ale_pkg::DATA_W-1:0] res_value_q;
	logic [ale_pkg::IDX_W-1:0]  res_index_q;

	logic                       out_valid_q;
	logic [ale_pkg::ST_W-1:0]   out_status_q;
	logic [ale_pkg::DATA_W-1:0] out_value_q;
	logic [ale_pkg::IDX_W-1:0]  out_index_q;
	logic [ale_pkg::CNT_W-1:0]  out_count_q;
	logic                       out_last_q;

	logic [ale_pkg::IDX_W-1:0]  raddr;
	logic [ale_pkg::IDX_W-1:0]  waddr;
	logic [ale_pkg::DATA_W-1:0] wdata;
	logic [ale_pkg::DATA_W-1:0] rdata;
	logic [ale_pkg::CNT_W-1:0]  last_idx;
	logic [ale_pkg::CNT_W-1:0]  cur_ext;
	logic [ale_pkg::CNT_W-1:0]  cur_next;
	logic [ale_pkg::ST_W-1:0]   err;
	logic [ale_pkg::IDX_W-1:0]  res_index_d;
	logic                       out_free;

	assign last_idx = cnt_q - ale_pkg::CNT_W'(1);
	assign cur_ext  = ale_pkg::CNT_W'(cur_q);
	assign cur_next = cur_ext + ale_pkg::CNT_W'(1);
	assign out_free = !out_valid_q || out_ready;

	// fault check on the incoming beat
	always_comb begin
		err = ale_pkg::ST_OK;
		case (command)
			ale_pkg::CMD_INS_POS: begin
				if (cnt_q >= ale_pkg::CNT_W'(ale_pkg::CAPACITY))
					err = ale_pkg::ST_FULL;
				else if (position > cnt_q)
					err = ale_pkg::ST_BADPOS;
			end
			ale_pkg::CMD_INS_SORT: begin
				if (cnt_q >= ale_pkg::CNT_W'(ale_pkg::CAPACITY))
					err = ale_pkg::ST_FULL;
			end
			ale_pkg::CMD_DEL: begin
				if (cnt_q == '0)
					err = ale_pkg::ST_EMPTY;
				else if (position >= cnt_q)
					err = ale_pkg::ST_BADPOS;
			end
			ale_pkg::CMD_LOC, ale_pkg::CMD_DUMP: begin
				if (cnt_q == '0)
					err = ale_pkg::ST_EMPTY;
			end
			default: err = ale_pkg::ST_OK;
		endcase
	end

	// cur_q always names the entry that rdata holds
	always_comb begin
		case (ctl.rsel)
			ale_pkg::RS_INC:  raddr = cur_q + ale_pkg::IDX_W'(1);
			ale_pkg::RS_DEC:  raddr = cur_q - ale_pkg::IDX_W'(1);
			ale_pkg::RS_LAST: raddr = last_idx[ale_pkg::IDX_W-1:0];
			ale_pkg::RS_POS:  raddr = position[ale_pkg::IDX_W-1:0];
			ale_pkg::RS_ZERO: raddr = '0;
			default:          raddr = cur_q;
		endcase
	end

	always_comb begin
		case (ctl.wsel)
			ale_pkg::WS_UP:    waddr = cur_q + ale_pkg::IDX_W'(1);
			ale_pkg::WS_DN:    waddr = cur_q - ale_pkg::IDX_W'(1);
			ale_pkg::WS_PLACE: waddr = ins_q;
			default:           waddr = cur_q;
		endcase
		wdata = (ctl.wsel == ale_pkg::WS_PLACE) ? val_q : rdata;
	end

	always_comb begin
		case (ctl.res_isel)
			ale_pkg::IS_INS: res_index_d = ins_q;
			ale_pkg::IS_POS: res_index_d = pos_q[ale_pkg::IDX_W-1:0];
			ale_pkg::IS_CUR: res_index_d = cur_q;
			default:         res_index_d = '0;
		endcase
	end

	ale_ram #(
		.WIDTH(ale_pkg::DATA_W),
		.DEPTH(ale_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ctl.we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		cur_q <= raddr;
		if (ctl.ld_in) begin
			cmd_q <= command;
			val_q <= value;
			pos_q <= position;
		end
		if (ctl.ins_ld)
			ins_q <= ctl.ins_inc ? cur_q + ale_pkg::IDX_W'(1) : '0;
		if (ctl.res_ld) begin
			res_status_q <= ctl.res_status;
			res_value_q  <= ctl.res_vrd ? rdata : '0;
			res_index_q  <= res_index_d;
		end
		if (ctl.out_ld) begin
			if (ctl.out_dump) begin
				out_status_q <= ale_pkg::ST_OK;
				out_value_q  <= rdata;
				out_index_q  <= cur_q;
				out_last_q   <= sts.at_end;
			end else begin
				out_status_q <= res_status_q;
				out_value_q  <= res_value_q;
				out_index_q  <= res_index_q;
				out_last_q   <= 1'b1;
			end
			out_count_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.cnt_inc)
				cnt_q <= cnt_q + ale_pkg::CNT_W'(1);
			else if (ctl.cnt_dec)
				cnt_q <= cnt_q - ale_pkg::CNT_W'(1);
			if (ctl.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.err      = err;
		sts.cnt_zero = (cnt_q == '0);
		sts.cont     = (cmd_q == ale_pkg::CMD_INS_SORT) ?
			($signed(rdata) > $signed(val_q)) : (cur_ext >= pos_q);
		sts.cur_zero = (cur_q == '0);
		sts.at_end   = (cur_next == cnt_q);
		sts.first    = (cur_ext == pos_q);
		sts.match    = (rdata == val_q);
		sts.out_free = out_free;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign value_out   = out_value_q;
	assign index_out   = out_index_q;
	assign entry_count = out_count_q;
	assign last        = out_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ale_pkg::CNT_W'(ale_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> out_free)
		else $error("result loaded over an untaken beat");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + ale_pkg::CNT_W'(1)) ||
			(cnt_q == $past(cnt_q) - ale_pkg::CNT_W'(1)))
		else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire

// ----- rtl/ale_ctrl.sv -----
`default_nettype none

module ale_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [ale_pkg::CMD_W-1:0] command,
	output logic                           in_ready,
	input  wire ale_pkg::ale_sts_t         sts,
	output ale_pkg::ale_ctl_t              ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_PLACE = 3'd2;
	localparam logic [2:0] S_DN    = 3'd3;
	localparam logic [2:0] S_LOC   = 3'd4;
	localparam logic [2:0] S_DUMP  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       fault;

	assign fault = (sts.err != ale_pkg::ST_OK);

	always_comb begin
		ctl            = '0;
		ctl.rsel       = ale_pkg::RS_HOLD;
		ctl.res_status = ale_pkg::ST_OK;
		ctl.res_isel   = ale_pkg::IS_ZERO;
		state_d        = state_q;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.ld_in      = 1'b1;
					ctl.res_status = sts.err;
					unique case (command) inside
						ale_pkg::CMD_INS_POS, ale_pkg::CMD_INS_SORT: begin
							if (fault) begin
								ctl.res_ld = 1'b1;
								state_d    = S_FIN;
							end else if (sts.cnt_zero) begin
								ctl.ins_ld = 1'b1;
								state_d    = S_PLACE;
							end else begin
								ctl.rsel = ale_pkg::RS_LAST;
								state_d  = S_UP;
							end
						end
						ale_pkg::CMD_DEL: begin
							if (fault) begin
								ctl.res_ld = 1'b1;
								state_d    = S_FIN;
							end else begin
								ctl.rsel = ale_pkg::RS_POS;
								state_d  = S_DN;
							end
						end
						ale_pkg::CMD_LOC: begin
							if (fault) begin
								ctl.res_ld = 1'b1;
								state_d    = S_FIN;
							end else begin
								ctl.rsel = ale_pkg::RS_ZERO;
								state_d  = S_LOC;
							end
						end
						ale_pkg::CMD_DUMP: begin
							if (fault) begin
								ctl.res_ld = 1'b1;
								state_d    = S_FIN;
							end else begin
								ctl.rsel = ale_pkg::RS_ZERO;
								state_d  = S_DUMP;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			// walk down from the top, moving entries up until the slot is found
			S_UP: begin
				if (sts.cont) begin
					ctl.we   = 1'b1;
					ctl.wsel = ale_pkg::WS_UP;
					if (sts.cur_zero) begin
						ctl.ins_ld = 1'b1;
						state_d    = S_PLACE;
					end else begin
						ctl.rsel = ale_pkg::RS_DEC;
					end
				end else begin
					ctl.ins_ld  = 1'b1;
					ctl.ins_inc = 1'b1;
					state_d     = S_PLACE;
				end
			end
			S_PLACE: begin
				ctl.we       = 1'b1;
				ctl.wsel     = ale_pkg::WS_PLACE;
				ctl.cnt_inc  = 1'b1;
				ctl.res_ld   = 1'b1;
				ctl.res_isel = ale_pkg::IS_INS;
				state_d      = S_FIN;
			end
			// first beat captures the removed entry, later ones move entries down
			S_DN: begin
				if (sts.first) begin
					ctl.res_ld   = 1'b1;
					ctl.res_vrd  = 1'b1;
					ctl.res_isel = ale_pkg::IS_POS;
				end else begin
					ctl.we   = 1'b1;
					ctl.wsel = ale_pkg::WS_DN;
				end
				if (sts.at_end) begin
					ctl.cnt_dec = 1'b1;
					state_d     = S_FIN;
				end else begin
					ctl.rsel = ale_pkg::RS_INC;
				end
			end
			S_LOC: begin
				if (sts.match) begin
					ctl.res_ld   = 1'b1;
					ctl.res_isel = ale_pkg::IS_CUR;
					state_d      = S_FIN;
				end else if (sts.at_end) begin
					ctl.res_ld     = 1'b1;
					ctl.res_status = ale_pkg::ST_NOTFOUND;
					state_d        = S_FIN;
				end else begin
					ctl.rsel = ale_pkg::RS_INC;
				end
			end
			S_DUMP: begin
				if (sts.out_free) begin
					ctl.out_ld   = 1'b1;
					ctl.out_dump = 1'b1;
					if (sts.at_end)
						state_d = S_IDLE;
					else
						ctl.rsel = ale_pkg::RS_INC;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_unused_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command > ale_pkg::CMD_DUMP) |=> state_q == S_IDLE)
		else $error("unused command left the idle state");

	a_fault_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command <= ale_pkg::CMD_DUMP && fault) |=>
			state_q == S_FIN)
		else $error("faulted command did not go straight to its result");
`endif

endmodule

`default_nettype wire

// ----- rtl/array_list_engine_unit.sv -----
// array list engine: a bounded list of up to 16 signed 32-bit entries
// input channel (in_valid/in_ready) takes one command beat: command, value, position
// output channel (out_valid/out_ready) returns result beats; last marks the final one
// every command gives one result beat, except dump on a non-empty list, which gives one per entry,
// and unused command codes, which give none
// in_ready is high only while the controller is idle, so commands run one at a time
// dump sends one entry per cycle from the single read port of the entry ram unless the
// output stalls; faults (full, empty, bad position) go straight to their result beat
// the entry ram has one write and one registered read port; walks move one entry a cycle
// the result sits in an output register, so a stalled receiver only delays the final beat
// (each beat of a dump) and the next command can be taken once that beat is loaded
// reset empties the list at once; entry contents are not cleared
`default_nettype none

module array_list_engine_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [ale_pkg::CMD_W-1:0]           command,
	input  wire logic signed [ale_pkg::DATA_W-1:0]   value,
	input  wire logic [ale_pkg::CNT_W-1:0]           position,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [ale_pkg::ST_W-1:0]                 status,
	output logic signed [ale_pkg::DATA_W-1:0]        value_out,
	output logic [ale_pkg::IDX_W-1:0]                index_out,
	output logic [ale_pkg::CNT_W-1:0]                entry_count,
	output logic                                     last
);

	ale_pkg::ale_ctl_t ctl;
	ale_pkg::ale_sts_t sts;

	ale_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.command (command),
		.in_ready(in_ready),
		.sts     (sts),
		.ctl     (ctl)
	);

	ale_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.value      (value),
		.position   (position),
		.ctl        (ctl),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.value_out  (value_out),
		.index_out  (index_out),
		.entry_count(entry_count),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- tb/array_list_engine_unit_test.sv -----
`timescale 1ns / 100ps

module array_list_engine_unit_test;

	localparam int STALL_LIMIT = 1000;
	localparam int CALM_TAIL   = 40;
	localparam int SETTLE      = 40;
	localparam int RANDOM_CMDS = 225;

	typedef struct {
		logic [ale_pkg::CMD_W-1:0]         cmd;
		logic signed [ale_pkg::DATA_W-1:0] val;
		logic [ale_pkg::CNT_W-1:0]         pos;
	} list_cmd_t;

	typedef struct {
		logic [ale_pkg::ST_W-1:0]          st;
		logic signed [ale_pkg::DATA_W-1:0] val;
		logic [ale_pkg::IDX_W-1:0]         idx;
		logic [ale_pkg::CNT_W-1:0]         cnt;
		logic                              fin;
	} list_beat_t;

	logic                              clk;
	logic                              arst_n      = 1'b0;
	logic                              in_valid    = 1'b0;
	logic                              in_ready;
	logic [ale_pkg::CMD_W-1:0]         command     = '0;
	logic signed [ale_pkg::DATA_W-1:0] value       = '0;
	logic [ale_pkg::CNT_W-1:0]         position    = '0;
	logic                              out_valid;
	logic                              out_ready   = 1'b0;
	logic [ale_pkg::ST_W-1:0]          status;
	logic signed [ale_pkg::DATA_W-1:0] value_out;
	logic [ale_pkg::IDX_W-1:0]         index_out;
	logic [ale_pkg::CNT_W-1:0]         entry_count;
	logic                              last;

	// predicted list contents and the beats it owes
	logic signed [ale_pkg::DATA_W-1:0] list_vals [ale_pkg::CAPACITY];
	int                                list_len = 0;
	list_beat_t                        owed_beats[$];
	list_cmd_t                         cmd_queue[$];

	int gen_len      = 0;
	int queued_total = 0;
	int taken_total  = 0;
	int fail_count   = 0;
	int quiet_cycles = 0;
	int in_gap       = 0;
	int out_gap      = 0;

	array_list_engine_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.value_out   (value_out),
		.index_out   (index_out),
		.entry_count (entry_count),
		.last        (last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void owe_beat(logic [ale_pkg::ST_W-1:0] st,
			logic signed [ale_pkg::DATA_W-1:0] v, int idx, logic fin);
		list_beat_t b;
		b.st  = st;
		b.val = v;
		b.idx = ale_pkg::IDX_W'(idx);
		b.cnt = ale_pkg::CNT_W'(list_len);
		b.fin = fin;
		owed_beats.push_back(b);
	endfunction

	function automatic void apply_list_cmd(list_cmd_t c);
		int slot;
		int k;
		int hit;
		logic signed [ale_pkg::DATA_W-1:0] gone;
		case (c.cmd)
			ale_pkg::CMD_INS_POS, ale_pkg::CMD_INS_SORT: begin
				if (list_len >= ale_pkg::CAPACITY)
					owe_beat(ale_pkg::ST_FULL, '0, 0, 1'b1);
				else if (c.cmd == ale_pkg::CMD_INS_POS && c.pos > list_len)
					owe_beat(ale_pkg::ST_BADPOS, '0, 0, 1'b1);
				else begin
					if (c.cmd == ale_pkg::CMD_INS_POS)
						slot = c.pos;
					else begin
						// sorted insert lands after any equal entries
						slot = list_len;
						while (slot > 0 && list_vals[slot-1] > c.val)
							slot--;
					end
					for (k = list_len; k > slot; k--)
						list_vals[k] = list_vals[k-1];
					list_vals[slot] = c.val;
					list_len++;
					owe_beat(ale_pkg::ST_OK, '0, slot, 1'b1);
				end
			end
			ale_pkg::CMD_DEL: begin
				if (list_len == 0)
					owe_beat(ale_pkg::ST_EMPTY, '0, 0, 1'b1);
				else if (c.pos >= list_len)
					owe_beat(ale_pkg::ST_BADPOS, '0, 0, 1'b1);
				else begin
					gone = list_vals[c.pos];
					for (k = c.pos; k + 1 < list_len; k++)
						list_vals[k] = list_vals[k+1];
					list_len--;
					owe_beat(ale_pkg::ST_OK, gone, c.pos, 1'b1);
				end
			end
			ale_pkg::CMD_LOC: begin
				hit = -1;
				for (k = list_len - 1; k >= 0; k--)
					if (list_vals[k] == c.val)
						hit = k;
				if (list_len == 0)
					owe_beat(ale_pkg::ST_EMPTY, '0, 0, 1'b1);
				else if (hit < 0)
					owe_beat(ale_pkg::ST_NOTFOUND, '0, 0, 1'b1);
				else
					owe_beat(ale_pkg::ST_OK, '0, hit, 1'b1);
			end
			ale_pkg::CMD_DUMP: begin
				if (list_len == 0)
					owe_beat(ale_pkg::ST_EMPTY, '0, 0, 1'b1);
				for (k = 0; k < list_len; k++)
					owe_beat(ale_pkg::ST_OK, list_vals[k], k, k + 1 == list_len);
			end
			default: ;
		endcase
	endfunction

	// shadow length lets the plan aim positions at the live part of the list
	function automatic void plan_cmd(logic [ale_pkg::CMD_W-1:0] cmd,
			logic signed [ale_pkg::DATA_W-1:0] val, logic [ale_pkg::CNT_W-1:0] pos);
		list_cmd_t c;
		c.cmd = cmd;
		c.val = val;
		c.pos = pos;
		cmd_queue.push_back(c);
		queued_total++;
		if ((cmd == ale_pkg::CMD_INS_POS && gen_len < ale_pkg::CAPACITY && pos <= gen_len) ||
				(cmd == ale_pkg::CMD_INS_SORT && gen_len < ale_pkg::CAPACITY))
			gen_len++;
		else if (cmd == ale_pkg::CMD_DEL && pos < gen_len)
			gen_len--;
	endfunction

	function automatic logic signed [ale_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return {1'b0, {(ale_pkg::DATA_W-1){1'b1}}};
			1:       return {1'b1, {(ale_pkg::DATA_W-1){1'b0}}};
			2, 3:    return $urandom;
			default: return $signed($urandom_range(0, 12)) - 6;
		endcase
	endfunction

	function automatic logic [ale_pkg::CNT_W-1:0] pick_pos(int span);
		if ($urandom_range(0, 9) == 0)
			return ale_pkg::CNT_W'($urandom);
		return ale_pkg::CNT_W'($urandom_range(0, (span < 0) ? 0 : span));
	endfunction

	function automatic bit may_idle();
		return cmd_queue.size() > CALM_TAIL && (cmd_queue.size() / 30) % 4 != 0;
	endfunction

	always @(posedge clk) begin : drive_commands
		list_cmd_t nxt;
		logic      send;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				nxt.cmd = command;
				nxt.val = value;
				nxt.pos = position;
				apply_list_cmd(nxt);
				taken_total++;
			end
			// a beat on offer stays put until it is taken
			if (!in_valid || in_ready) begin
				send = 1'b0;
				if (in_gap > 0)
					in_gap--;
				else if (cmd_queue.size() > 0) begin
					if (may_idle() && $urandom_range(0, 4) == 0)
						in_gap = $urandom_range(0, 2);
					else
						send = 1'b1;
				end
				if (send) begin
					nxt = cmd_queue.pop_front();
					command  <= nxt.cmd;
					value    <= nxt.val;
					position <= nxt.pos;
				end
				in_valid <= send;
			end
		end
	end

	always @(posedge clk) begin : check_results
		list_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (owed_beats.size() == 0) begin
					$error("unexpected result beat: status %0d value_out %0d", status, value_out);
					fail_count++;
				end else begin
					want = owed_beats.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (value_out !== want.val) begin
						$error("value_out: expected %0d, got %0d", want.val, value_out);
						fail_count++;
					end
					if (index_out !== want.idx) begin
						$error("index_out: expected %0d, got %0d", want.idx, index_out);
						fail_count++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
						fail_count++;
					end
					if (last !== want.fin) begin
						$error("last: expected %0d, got %0d", want.fin, last);
						fail_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (may_idle() && $urandom_range(0, 4) == 0) begin
				out_gap = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : run_test
		int  counted;
		int  settle;
		int  roll;
		int  grow_share;
		bit  timed_out;
		logic [ale_pkg::CMD_W-1:0] cmd;

		// empty faults, extremes, sorted duplicates, bad positions, an unused command, full list
		plan_cmd(ale_pkg::CMD_DUMP, '0, '0);
		plan_cmd(ale_pkg::CMD_DEL, '0, '0);
		plan_cmd(ale_pkg::CMD_LOC, '0, '0);
		plan_cmd(ale_pkg::CMD_INS_POS, 32'sd9, 5'd1);
		plan_cmd(ale_pkg::CMD_INS_POS, {1'b0, {(ale_pkg::DATA_W-1){1'b1}}}, 5'd0);
		plan_cmd(ale_pkg::CMD_INS_POS, {1'b1, {(ale_pkg::DATA_W-1){1'b0}}}, 5'd0);
		plan_cmd(ale_pkg::CMD_INS_SORT, 32'sd0, 5'd0);
		plan_cmd(ale_pkg::CMD_INS_SORT, -32'sd1, 5'd0);
		plan_cmd(ale_pkg::CMD_INS_SORT, 32'sd0, 5'd0);
		plan_cmd(ale_pkg::CMD_LOC, 32'sd0, 5'd0);
		plan_cmd(ale_pkg::CMD_LOC, 32'sd5, 5'd0);
		plan_cmd(ale_pkg::CMD_DEL, '0, ale_pkg::CNT_W'(gen_len));
		plan_cmd(ale_pkg::CMD_INS_POS, 32'sd3, 5'd31);
		plan_cmd(3'd7, 32'sd1, 5'd0);
		while (gen_len < ale_pkg::CAPACITY)
			plan_cmd(ale_pkg::CMD_INS_SORT, pick_value(), '0);
		plan_cmd(ale_pkg::CMD_INS_POS, 32'sd4, 5'd0);
		plan_cmd(ale_pkg::CMD_DUMP, '0, '0);
		plan_cmd(ale_pkg::CMD_DEL, '0, ale_pkg::CNT_W'(ale_pkg::CAPACITY - 1));

		// random walk that swings between growing and shrinking the list
		counted = 0;
		while (counted < RANDOM_CMDS) begin
			grow_share = ((counted / 40) % 2 == 0) ? 55 : 25;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				cmd = ale_pkg::CMD_W'($urandom_range(5, 7));
			else if (roll < 8)
				cmd = ale_pkg::CMD_DUMP;
			else if (roll < 20)
				cmd = ale_pkg::CMD_LOC;
			else if (roll < 20 + grow_share)
				cmd = $urandom_range(0, 1) ? ale_pkg::CMD_INS_SORT : ale_pkg::CMD_INS_POS;
			else
				cmd = ale_pkg::CMD_DEL;
			if (cmd == ale_pkg::CMD_DEL)
				plan_cmd(cmd, pick_value(), pick_pos(gen_len - 1));
			else
				plan_cmd(cmd, pick_value(), pick_pos(gen_len));
			if (cmd <= ale_pkg::CMD_DUMP)
				counted++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		timed_out = 1'b0;
		while (!timed_out && (taken_total < queued_total || owed_beats.size() > 0)) begin
			@(posedge clk);
			if (quiet_cycles >= STALL_LIMIT) begin
				$error("no beat moved in %0d cycles", quiet_cycles);
				timed_out = 1'b1;
			end
		end
		settle = 0;
		while (!timed_out && settle < SETTLE) begin
			@(posedge clk);
			settle++;
		end
		if (owed_beats.size() != 0) begin
			$error("%0d result beats never arrived", owed_beats.size());
			fail_count++;
		end

		if (!timed_out && fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- array_list_engine_unit.f -----
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/ale_dp.sv
rtl/ale_ctrl.sv
rtl/array_list_engine_unit.sv
tb/array_list_engine_unit_test.sv
